// ===== hdl/irr_pkg.sv =====
`default_nettype none

package irr_pkg;

   localparam int MAX_VERTICES_DEFAULT = 1024;
   localparam int COUNT_BITS_DEFAULT   = 16;

   localparam int VERTEX_BITS       = 10;
   localparam int FUNC_BITS         = 2;
   localparam int POSITION_BITS     = 10;
   localparam int DEGREE_BITS       = 16;
   localparam int NUM_VERTICES_BITS = 11;
   localparam int NUM_VERTICES_MAX  = (2 ** NUM_VERTICES_BITS) - 1;

   localparam logic [NUM_VERTICES_BITS-1:0] NUM_VERTICES_RESET = 11'd1024;

   // Depth of the command queue and of the result queue.
   localparam int QUEUE_DEPTH = 2;

   localparam logic [FUNC_BITS-1:0] FUNC_EDGE  = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_QUERY = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      OP_EDGE      = 2'd0,
      OP_QUERY     = 2'd1,
      OP_QUERY_OOR = 2'd2,
      OP_CLEAR     = 2'd3
   } op_type;

   typedef struct packed {
      logic [FUNC_BITS-1:0]   func;
      logic [VERTEX_BITS-1:0] vertex;
   } req_type;

   typedef struct packed {
      logic [POSITION_BITS-1:0] new_position;
      logic [DEGREE_BITS-1:0]   in_degree;
      logic                     out_of_range;
   } rsp_type;

   typedef struct packed {
      op_type                 op;
      logic [VERTEX_BITS-1:0] vertex;
   } cmd_type;

endpackage

`default_nettype wire

// ===== hdl/irr_ram.sv =====
`default_nettype none

module irr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/irr_fifo.sv =====
`default_nettype none

module irr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rd_data,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/irr_front.sv =====
`default_nettype none

module irr_front #(
   parameter int MAX_VERTICES = irr_pkg::MAX_VERTICES_DEFAULT,
   localparam int NCAP = (MAX_VERTICES < irr_pkg::NUM_VERTICES_MAX) ?
                         MAX_VERTICES : irr_pkg::NUM_VERTICES_MAX,
   localparam int NW = $clog2(NCAP + 1)
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     csr_valid,
   output logic                                          csr_ready,
   input  wire logic [irr_pkg::NUM_VERTICES_BITS-1:0]    csr_data,
   input  wire logic                                     req_push,
   output logic                                          req_full,
   input  wire irr_pkg::req_type                         req_data,
   input  wire logic                                     cmd_full,
   input  wire logic                                     init_busy,
   output logic                                          cmd_push,
   output irr_pkg::cmd_type                              cmd_data,
   output logic      [NW-1:0]                            active_count
);

   localparam int CMPW = (NW > irr_pkg::VERTEX_BITS) ? NW : irr_pkg::VERTEX_BITS;
   localparam logic [irr_pkg::NUM_VERTICES_BITS-1:0] NV_CAP =
      irr_pkg::NUM_VERTICES_BITS'(NCAP);

   logic [irr_pkg::NUM_VERTICES_BITS-1:0] num_vertices_ff, num_vertices_in;
   logic [irr_pkg::NUM_VERTICES_BITS-1:0] clamped;
   logic                                  accept;
   logic                                  in_range;
   logic                                  keep;

   assign csr_ready = 1'b1;

   always_comb begin
      num_vertices_in = num_vertices_ff;
      if (csr_valid) begin
         num_vertices_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_vertices_ff <= irr_pkg::NUM_VERTICES_RESET;
      end else begin
         num_vertices_ff <= num_vertices_in;
      end
   end

   assign clamped      = (num_vertices_ff > NV_CAP) ? NV_CAP : num_vertices_ff;
   assign active_count = NW'(clamped);

   assign req_full = cmd_full || init_busy;
   assign accept   = req_push && !req_full;
   assign in_range = CMPW'(req_data.vertex) < CMPW'(active_count);

   // Edges to ids out of range and the unused function code are dropped here.
   always_comb begin
      keep            = 1'b0;
      cmd_data.op     = irr_pkg::OP_CLEAR;
      cmd_data.vertex = req_data.vertex;
      unique case (req_data.func)
         irr_pkg::FUNC_EDGE: begin
            keep        = in_range;
            cmd_data.op = irr_pkg::OP_EDGE;
         end
         irr_pkg::FUNC_QUERY: begin
            keep        = 1'b1;
            cmd_data.op = in_range ? irr_pkg::OP_QUERY : irr_pkg::OP_QUERY_OOR;
         end
         irr_pkg::FUNC_CLEAR: begin
            keep        = 1'b1;
            cmd_data.op = irr_pkg::OP_CLEAR;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign cmd_push = accept && keep;

endmodule

`default_nettype wire

// ===== hdl/irr_back.sv =====
`default_nettype none

module irr_back #(
   parameter int MAX_VERTICES = irr_pkg::MAX_VERTICES_DEFAULT,
   parameter int COUNT_BITS   = irr_pkg::COUNT_BITS_DEFAULT,
   localparam int NCAP = (MAX_VERTICES < irr_pkg::NUM_VERTICES_MAX) ?
                         MAX_VERTICES : irr_pkg::NUM_VERTICES_MAX,
   localparam int NW = $clog2(NCAP + 1),
   localparam int AW = $clog2(MAX_VERTICES)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [NW-1:0]         active_count,
   input  wire logic                  cmd_empty,
   input  wire irr_pkg::cmd_type      cmd_data,
   output logic                       cmd_pop,
   input  wire logic                  rsp_full,
   output logic                       rsp_push,
   output irr_pkg::rsp_type           rsp_data,
   output logic                       init_busy,
   output logic                       ram_wr_en,
   output logic      [AW-1:0]         ram_wr_addr,
   output logic      [COUNT_BITS-1:0] ram_wr_data,
   output logic                       ram_rd_en,
   output logic      [AW-1:0]         ram_rd_addr,
   input  wire logic [COUNT_BITS-1:0] ram_rd_data
);

   localparam int CMPW = (NW > irr_pkg::VERTEX_BITS) ? NW : irr_pkg::VERTEX_BITS;
   localparam logic [AW-1:0]         LAST_ADDR = AW'(MAX_VERTICES - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [5:0] {
      ST_INIT  = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_CLEAR = 6'b000100,
      ST_EDGE  = 6'b001000,
      ST_QREF  = 6'b010000,
      ST_SCAN  = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   irr_pkg::cmd_type      cmd_ff, cmd_in;
   logic [AW-1:0]         sweep_ff, sweep_in;
   logic [COUNT_BITS-1:0] ref_ff, ref_in;
   logic [NW-1:0]         rank_ff, rank_in;
   logic [NW-1:0]         scan_ff, scan_in;
   logic [NW-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic                  hit;
   logic [NW-1:0]         rank_next;
   logic [NW-1:0]         last_idx;

   assign init_busy = (state_ff == ST_INIT);
   assign last_idx  = active_count - 1'b1;

   // A stored pair ranks above the queried one on a larger count, or on an
   // equal count with a larger id.
   assign hit = cmp_valid_ff &&
                ((ram_rd_data > ref_ff) ||
                 ((ram_rd_data == ref_ff) &&
                  (CMPW'(cmp_idx_ff) > CMPW'(cmd_ff.vertex))));
   assign rank_next = rank_ff + NW'(hit);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      sweep_in     = sweep_ff;
      ref_in       = ref_ff;
      rank_in      = rank_ff;
      scan_in      = scan_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = 1'b0;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      rsp_data     = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = sweep_ff;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = AW'(cmd_data.vertex);

      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            ram_wr_en = 1'b1;
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == LAST_ADDR) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // Waiting for room in the result queue keeps it free for the
            // result of whatever is taken now.
            if (!cmd_empty && !rsp_full) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_data;
               unique case (cmd_data.op)
                  irr_pkg::OP_EDGE: begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_EDGE;
                  end
                  irr_pkg::OP_QUERY: begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_QREF;
                  end
                  irr_pkg::OP_QUERY_OOR: begin
                     rsp_push              = 1'b1;
                     rsp_data.out_of_range = 1'b1;
                  end
                  irr_pkg::OP_CLEAR: begin
                     sweep_in = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_EDGE: begin
            ram_wr_addr = AW'(cmd_ff.vertex);
            ram_wr_data = ram_rd_data + 1'b1;
            ram_wr_en   = (ram_rd_data != COUNT_MAX);
            state_in    = ST_IDLE;
         end
         ST_QREF: begin
            ref_in       = ram_rd_data;
            ram_rd_en    = 1'b1;
            ram_rd_addr  = '0;
            scan_in      = NW'(1);
            cmp_idx_in   = '0;
            cmp_valid_in = 1'b1;
            rank_in      = '0;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            rank_in = rank_next;
            if (scan_ff < active_count) begin
               ram_rd_en    = 1'b1;
               ram_rd_addr  = AW'(scan_ff);
               cmp_idx_in   = scan_ff;
               cmp_valid_in = 1'b1;
               scan_in      = scan_ff + 1'b1;
            end
            if (cmp_valid_ff && (cmp_idx_ff == last_idx)) begin
               rsp_push              = 1'b1;
               rsp_data.new_position = irr_pkg::POSITION_BITS'(rank_next);
               rsp_data.in_degree    = irr_pkg::DEGREE_BITS'(ref_ff);
               rsp_data.out_of_range = 1'b0;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      ref_ff     <= ref_in;
      rank_ff    <= rank_in;
      scan_ff    <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
   end

endmodule

`default_nettype wire

// ===== hdl/in_degree_rank_reorder_core.sv =====
`default_nettype none

// Channel   Direction  Handshake                 Payload
// req_      in         req_push / req_full       irr_pkg::req_type (func, vertex)
// rsp_      out        rsp_pop / rsp_empty       irr_pkg::rsp_type
// csr_      in         csr_valid / csr_ready     num_vertices, 11 bits
//
// The engine owns the count memory and takes one command at a time from a
// two-entry queue. An edge reads its count, then writes it back; a clear
// sweeps the whole memory; an in-range query reads its own count, then scans
// one count per cycle over n = min(num_vertices, MAX_VERTICES) ids; an
// out-of-range query is answered when it is taken. After reset the memory is
// swept to zero with req_full high; a command waits for result-queue room.

module in_degree_rank_reorder_core #(
   parameter int MAX_VERTICES = irr_pkg::MAX_VERTICES_DEFAULT,
   parameter int COUNT_BITS   = irr_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_push,
   output logic                                       req_full,
   input  wire irr_pkg::req_type                      req_data,
   output logic                                       rsp_empty,
   input  wire logic                                  rsp_pop,
   output irr_pkg::rsp_type                           rsp_data,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [irr_pkg::NUM_VERTICES_BITS-1:0] csr_data
);

   localparam int NCAP = (MAX_VERTICES < irr_pkg::NUM_VERTICES_MAX) ?
                         MAX_VERTICES : irr_pkg::NUM_VERTICES_MAX;
   localparam int NW = $clog2(NCAP + 1);
   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CMD_BITS = $bits(irr_pkg::cmd_type);
   localparam int RSP_BITS = $bits(irr_pkg::rsp_type);

   logic                  cmd_full, cmd_empty, cmd_push, cmd_pop;
   irr_pkg::cmd_type      front_cmd, back_cmd;
   logic [CMD_BITS-1:0]   cmd_q_out;
   logic [NW-1:0]         active_count;
   logic                  init_busy;
   logic                  rsp_full, rsp_push;
   irr_pkg::rsp_type      back_rsp;
   logic [RSP_BITS-1:0]   rsp_q_out;
   logic                  ram_wr_en, ram_rd_en;
   logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
   logic [COUNT_BITS-1:0] ram_wr_data, ram_rd_data;

   irr_front #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .cmd_full     (cmd_full),
      .init_busy    (init_busy),
      .cmd_push     (cmd_push),
      .cmd_data     (front_cmd),
      .active_count (active_count)
   );

   irr_fifo #(
      .WIDTH(CMD_BITS),
      .DEPTH(irr_pkg::QUEUE_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (front_cmd),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_q_out),
      .empty   (cmd_empty)
   );

   assign back_cmd = irr_pkg::cmd_type'(cmd_q_out);

   irr_back #(
      .MAX_VERTICES(MAX_VERTICES),
      .COUNT_BITS  (COUNT_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .active_count (active_count),
      .cmd_empty    (cmd_empty),
      .cmd_data     (back_cmd),
      .cmd_pop      (cmd_pop),
      .rsp_full     (rsp_full),
      .rsp_push     (rsp_push),
      .rsp_data     (back_rsp),
      .init_busy    (init_busy),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data)
   );

   irr_ram #(
      .WIDTH(COUNT_BITS),
      .DEPTH(MAX_VERTICES)
   ) u_counts (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   irr_fifo #(
      .WIDTH(RSP_BITS),
      .DEPTH(irr_pkg::QUEUE_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (back_rsp),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_q_out),
      .empty   (rsp_empty)
   );

   assign rsp_data = irr_pkg::rsp_type'(rsp_q_out);

endmodule

`default_nettype wire

// ===== bench/tb_in_degree_rank_reorder_core.sv =====
module tb_in_degree_rank_reorder_core;
   import irr_pkg::*;

   localparam int MAX_IDS = MAX_VERTICES_DEFAULT;
   localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [DEGREE_BITS-1:0] DEGREE_FULL = '1;
   localparam int SETTLE_CYCLES = 3200;
   localparam int STALL_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 560;
   localparam int HOT_IDS = 8;
   localparam int BURST_EDGES = 6;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [NUM_VERTICES_BITS-1:0] csr_data = '0;

   // Transfers seen at the last rising edge, read by the drivers at the falling edge.
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic csr_fire = 1'b0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   int unsigned req_hold = 0;
   int unsigned rsp_hold = 0;
   int unsigned rsp_gap;

   req_type pending_items[$];
   rsp_type awaited_ranks[$];
   logic [DEGREE_BITS-1:0] degree_tally [MAX_IDS];
   logic [NUM_VERTICES_BITS-1:0] vertex_limit;
   logic [NUM_VERTICES_BITS-1:0] vertex_settings [9] =
      '{11'd2047, 11'd0, 11'd1, 11'd2, 11'd1023, 11'd1025, 11'd40, 11'd9, 11'd1024};

   int mismatches = 0;
   int idle_cycles = 0;
   int edges_seen = 0;
   int queries_seen = 0;
   int clears_seen = 0;
   int ignored_seen = 0;
   int results_checked = 0;
   int settings_used = 0;

   in_degree_rank_reorder_core DUT (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   function automatic int unsigned draw_gap(bit calm);
      if (calm) return 0;
      return $urandom_range(0, 18);
   endfunction

   function automatic int unsigned active_ids();
      return (vertex_limit > MAX_IDS) ? MAX_IDS : vertex_limit;
   endfunction

   // Position in a descending order by count; among equal counts the higher id leads.
   function automatic rsp_type rank_among_counts(logic [VERTEX_BITS-1:0] vertex);
      rsp_type answer;
      int unsigned n;
      int unsigned position;
      logic [DEGREE_BITS-1:0] own;
      answer = '0;
      n = active_ids();
      if (vertex >= n) begin
         answer.out_of_range = 1'b1;
         return answer;
      end
      own = degree_tally[vertex];
      position = 0;
      for (int i = 0; i < n; i++)
         if (degree_tally[i] > own || (degree_tally[i] == own && i > vertex))
            position++;
      answer.new_position = position[POSITION_BITS-1:0];
      answer.in_degree = own;
      return answer;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      if (mismatches < 40)
         $display("Mismatch at %0t, result %0d: %s got %0d, expected %0d",
                  $time, results_checked, what, got, want);
      mismatches++;
   endtask

   task automatic track_item(req_type item);
      int unsigned n;
      n = active_ids();
      case (item.func)
         FUNC_EDGE: begin
            edges_seen++;
            if (item.vertex < n && degree_tally[item.vertex] != DEGREE_FULL)
               degree_tally[item.vertex] = degree_tally[item.vertex] + 1'b1;
         end
         FUNC_QUERY: begin
            queries_seen++;
            awaited_ranks.push_back(rank_among_counts(item.vertex));
         end
         FUNC_CLEAR: begin
            clears_seen++;
            foreach (degree_tally[i]) degree_tally[i] = '0;
         end
         default: begin
            ignored_seen++;
         end
      endcase
   endtask

   task automatic check_result(rsp_type got);
      rsp_type want;
      if (awaited_ranks.size() == 0) begin
         report_mismatch("result with no query waiting, packed", got, 0);
         return;
      end
      want = awaited_ranks.pop_front();
      results_checked++;
      if (got.new_position !== want.new_position)
         report_mismatch("new_position", got.new_position, want.new_position);
      if (got.in_degree !== want.in_degree)
         report_mismatch("in_degree", got.in_degree, want.in_degree);
      if (got.out_of_range !== want.out_of_range)
         report_mismatch("out_of_range", got.out_of_range, want.out_of_range);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
         csr_fire <= 1'b0;
         vertex_limit = NUM_VERTICES_RESET;
         foreach (degree_tally[i]) degree_tally[i] = '0;
         idle_cycles = 0;
      end else begin
         req_fire <= req_push && !req_full;
         rsp_fire <= rsp_pop && !rsp_empty;
         csr_fire <= csr_valid && csr_ready;
         if (csr_valid && csr_ready)
            vertex_limit = csr_data;
         if (rsp_pop && !rsp_empty)
            check_result(rsp_data);
         if (req_push && !req_full)
            track_item(req_data);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                        idle_cycles, awaited_ranks.size());
               $display("*** FAILED ***");
               $finish;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         req_hold <= 0;
      end else if (req_push && !req_fire) begin
         // The item stays on the port until its transfer.
      end else if (req_hold != 0) begin
         req_push <= 1'b0;
         req_hold <= req_hold - 1;
      end else if (pending_items.size() != 0) begin
         req_data <= pending_items.pop_front();
         req_push <= 1'b1;
         req_hold <= draw_gap(req_calm);
      end else begin
         req_push <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         rsp_hold <= 1;
      end else if (rsp_fire) begin
         rsp_gap = draw_gap(rsp_calm);
         rsp_hold <= rsp_gap;
         rsp_pop <= (rsp_gap == 0);
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_pop <= (rsp_hold == 1);
      end
   end

   task automatic queue_item(logic [FUNC_BITS-1:0] func, logic [VERTEX_BITS-1:0] vertex);
      req_type item;
      item.func = func;
      item.vertex = vertex;
      pending_items.push_back(item);
   endtask

   // Most ids fall on a few hot vertices so that counts differ and ties get broken.
   task automatic queue_random_item(int unsigned n_eff);
      int unsigned pick;
      int unsigned vertex;
      pick = $urandom_range(0, 99);
      if (n_eff != 0 && $urandom_range(0, 9) < 6)
         vertex = $urandom_range(0, (n_eff < HOT_IDS ? n_eff : HOT_IDS) - 1);
      else if (n_eff != 0 && $urandom_range(0, 1) == 0)
         vertex = $urandom_range(0, n_eff - 1);
      else
         vertex = $urandom_range(0, MAX_IDS - 1);
      if (pick < 55)
         queue_item(FUNC_EDGE, vertex[VERTEX_BITS-1:0]);
      else if (pick < 93)
         queue_item(FUNC_QUERY, vertex[VERTEX_BITS-1:0]);
      else if (pick < 97)
         queue_item(FUNC_CLEAR, vertex[VERTEX_BITS-1:0]);
      else
         queue_item(FUNC_UNUSED, vertex[VERTEX_BITS-1:0]);
   endtask

   // A clear or an edge gives no result, so the engine may still be busy with queued
   // ones after the last result; the pause covers a full command queue of clears.
   task automatic settle_all();
      while (pending_items.size() != 0 || req_push) @(negedge clock);
      while (awaited_ranks.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_vertex_limit(logic [NUM_VERTICES_BITS-1:0] value);
      @(negedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      @(negedge clock);
      while (!csr_fire) @(negedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int unsigned n_eff;
      vertex_settings[7] = NUM_VERTICES_BITS'($urandom_range(3, 200));
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // With every count at zero the order is by id alone.
      queue_item(FUNC_QUERY, 10'd0);
      queue_item(FUNC_QUERY, 10'd1023);
      queue_item(FUNC_EDGE, 10'd5);
      queue_item(FUNC_EDGE, 10'd5);
      queue_item(FUNC_EDGE, 10'd5);
      queue_item(FUNC_EDGE, 10'd1023);
      queue_item(FUNC_EDGE, 10'd0);
      queue_item(FUNC_QUERY, 10'd5);
      queue_item(FUNC_QUERY, 10'd0);
      queue_item(FUNC_QUERY, 10'd1023);
      queue_item(FUNC_UNUSED, 10'd5);
      queue_item(FUNC_QUERY, 10'd5);
      queue_item(FUNC_CLEAR, 10'd1023);
      queue_item(FUNC_QUERY, 10'd5);
      settle_all();

      // Drive a burst of edges into one vertex back to back.
      req_calm = 1'b1;
      repeat (BURST_EDGES) queue_item(FUNC_EDGE, 10'd7);
      queue_item(FUNC_QUERY, 10'd7);
      queue_item(FUNC_QUERY, 10'd8);
      settle_all();

      // Each setting starts from an idle block; the counts left before it carry over
      // and drop out of ranks while their ids are out of range.
      foreach (vertex_settings[p]) begin
         write_vertex_limit(vertex_settings[p]);
         n_eff = (vertex_settings[p] > MAX_IDS) ? MAX_IDS : vertex_settings[p];
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         repeat (RANDOM_ITEMS / $size(vertex_settings)) queue_random_item(n_eff);
         settle_all();
      end

      $display("Covered %0d edges, %0d queries, %0d clears and %0d unused codes,",
               edges_seen, queries_seen, clears_seen, ignored_seen);
      $display("a back-to-back edge burst and %0d vertex-count settings; %0d results checked.",
               settings_used, results_checked);
      if (mismatches == 0 && awaited_ranks.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/irr_pkg.sv
hdl/irr_ram.sv
hdl/irr_fifo.sv
hdl/irr_front.sv
hdl/irr_back.sv
hdl/in_degree_rank_reorder_core.sv
bench/tb_in_degree_rank_reorder_core.sv
